>>> design/mbq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbq_pkg: shared definitions for the multichannel biquad low-pass filter
// Widths, register indexes and reset values of the Q4.28 coefficients.
// ---------------------------------------------------------------------------
package mbq_pkg;

   localparam int CHANNELS_DEF    = 32;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int CHAN_W          = 5;
   localparam int COEF_W          = 32;
   localparam int NUM_COEF        = 5;
   localparam int FRAC_BITS       = 28;
   localparam int CSR_IDX_W       = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NUM_COEF0,
      REG_NUM_COEF1,
      REG_NUM_COEF2,
      REG_DEN_COEF1,
      REG_DEN_COEF2
   } reg_idx_type;

   typedef logic signed [COEF_W-1:0] coef_type;

   localparam coef_type COEF_RESET [NUM_COEF] = '{
      32'sd268435456, 32'sd0, 32'sd0, 32'sd0, 32'sd0
   };

endpackage

>>> design/mbq_ifs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbq_ifs: channel interfaces of the multichannel biquad low-pass filter
// Sample request, filtered response and coefficient write channels.
// ---------------------------------------------------------------------------
interface mbq_req_if #(
   parameter int SAMPLE_BITS = mbq_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [mbq_pkg::CHAN_W-1:0]    channel;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output channel, output sample_in, input ready);
   modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface mbq_rsp_if #(
   parameter int SAMPLE_BITS = mbq_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [mbq_pkg::CHAN_W-1:0]    channel_out;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          saturated;

   modport source (output valid, output channel_out, output sample_out,
                   output saturated, input ready);
   modport sink   (input valid, input channel_out, input sample_out,
                   input saturated, output ready);
endinterface

interface mbq_csr_if;
   logic                          valid;
   logic                          ready;
   logic [mbq_pkg::CSR_IDX_W-1:0] index;
   logic [mbq_pkg::COEF_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/multichannel_biquad_lowpass.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multichannel_biquad_lowpass: direct form I biquad over many channels
// Per-channel history lives in one synchronous RAM, read on accept and
// written back when the result leaves the arithmetic stage.
// ---------------------------------------------------------------------------
// One transaction per cycle enters and leaves unless the response port or a
// same-channel hazard stalls; a result passes the multiply, sum and response
// registers. A sample that directly follows one of its own channel waits in
// the multiply stage until that one is summed, rounded, saturated and written
// back, since its feedback terms need that output.
// A channel number at or above CHANNELS is accepted and dropped with no
// response and no history change. History reads as zero after reset through
// one valid bit per channel; no clearing pass is needed.
// Coefficient writes are always ready outside reset.
// ---------------------------------------------------------------------------
module multichannel_biquad_lowpass #(
   parameter int CHANNELS    = mbq_pkg::CHANNELS_DEF,
   parameter int SAMPLE_BITS = mbq_pkg::SAMPLE_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mbq_req_if.sink   req_bus,
   mbq_rsp_if.source rsp_bus,
   mbq_csr_if.sink   csr_bus
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int P_W   = mbq_pkg::COEF_W + SAMPLE_BITS;
   localparam int ACC_W = (P_W + 3 > 64) ? 64 : P_W + 3;
   localparam int R_W   = ACC_W - mbq_pkg::FRAC_BITS;

   localparam logic signed [ACC_W-1:0] RND =
      ACC_W'(longint'(1) << (mbq_pkg::FRAC_BITS - 1));
   localparam logic signed [SAMPLE_BITS-1:0] MAX_S = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] MIN_S = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [R_W-1:0] MAX_R = R_W'(MAX_S);
   localparam logic signed [R_W-1:0] MIN_R = R_W'(MIN_S);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x1;
      logic signed [SAMPLE_BITS-1:0] x2;
      logic signed [SAMPLE_BITS-1:0] y1;
      logic signed [SAMPLE_BITS-1:0] y2;
   } state_type;

   // coefficients
   mbq_pkg::coef_type coef_ff [mbq_pkg::NUM_COEF];
   mbq_pkg::coef_type coef_in [mbq_pkg::NUM_COEF];

   // handshake and control
   logic             out_free;
   logic             s2_free;
   logic             hazard;
   logic             mv1;
   logic             s1_free;
   logic             accept;
   logic             in_range;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] idx1;
   logic             wr_en;
   state_type        wr_data;

   // history RAM
   state_type         state_ram_ff [CHANNELS];
   logic [CHANNELS-1:0] entry_vld_ff;
   state_type         rd_data_ff;
   logic              rd_vld_ff;
   logic              fwd_vld_ff, fwd_vld_in;
   state_type         fwd_data_ff, fwd_data_in;
   state_type         eff;

   // multiply stage
   logic                          v1_ff, v1_in;
   logic [mbq_pkg::CHAN_W-1:0]    ch1_ff, ch1_in;
   logic signed [SAMPLE_BITS-1:0] x_s1_ff, x_s1_in;

   // sum stage
   logic                          v2_ff, v2_in;
   logic [mbq_pkg::CHAN_W-1:0]    ch2_ff, ch2_in;
   logic signed [SAMPLE_BITS-1:0] x_s2_ff, x_s2_in;
   logic signed [SAMPLE_BITS-1:0] xp_s2_ff, xp_s2_in;
   logic signed [SAMPLE_BITS-1:0] yp_s2_ff, yp_s2_in;
   logic signed [P_W-1:0]         p0_ff, p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [P_W-1:0]         p0_in, p1_in, p2_in, p3_in, p4_in;
   logic signed [ACC_W-1:0]       acc;
   logic signed [R_W-1:0]         rnd;
   logic signed [SAMPLE_BITS-1:0] y;
   logic                          sat;

   // response register
   logic                          rsp_vld_ff, rsp_vld_in;
   logic [mbq_pkg::CHAN_W-1:0]    rsp_ch_ff, rsp_ch_in;
   logic signed [SAMPLE_BITS-1:0] rsp_y_ff, rsp_y_in;
   logic                          rsp_sat_ff, rsp_sat_in;

   // ---------------- coefficient registers ----------------
   assign csr_bus.ready = !reset;

   always_comb begin
      coef_in = coef_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         case (mbq_pkg::reg_idx_type'(csr_bus.index))
            mbq_pkg::REG_NUM_COEF0: coef_in[0] = csr_bus.data;
            mbq_pkg::REG_NUM_COEF1: coef_in[1] = csr_bus.data;
            mbq_pkg::REG_NUM_COEF2: coef_in[2] = csr_bus.data;
            mbq_pkg::REG_DEN_COEF1: coef_in[3] = csr_bus.data;
            mbq_pkg::REG_DEN_COEF2: coef_in[4] = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= mbq_pkg::COEF_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // ---------------- pipeline control ----------------
   assign out_free = !rsp_vld_ff || rsp_bus.ready;
   assign s2_free  = !v2_ff || out_free;
   assign hazard   = v1_ff && v2_ff && (ch1_ff == ch2_ff);
   assign mv1      = v1_ff && s2_free && !hazard;
   assign s1_free  = !v1_ff || mv1;

   assign req_bus.ready = s1_free && !reset;
   assign accept        = req_bus.valid && req_bus.ready;
   assign in_range      = int'(req_bus.channel) < CHANNELS;
   assign rd_idx        = IDX_W'(req_bus.channel);
   assign idx1          = IDX_W'(ch1_ff);
   assign wr_idx        = IDX_W'(ch2_ff);
   assign wr_en         = v2_ff && out_free;

   always_comb begin
      wr_data.x1 = x_s2_ff;
      wr_data.x2 = xp_s2_ff;
      wr_data.y1 = y;
      wr_data.y2 = yp_s2_ff;
   end

   // ---------------- history RAM, write-first ----------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_ram_ff[wr_idx] <= wr_data;
      end
      if (s1_free) begin
         rd_data_ff <= (wr_en && wr_idx == rd_idx) ? wr_data : state_ram_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            entry_vld_ff[wr_idx] <= 1'b1;
         end
         if (s1_free) begin
            rd_vld_ff <= (wr_en && wr_idx == rd_idx) || entry_vld_ff[rd_idx];
         end
      end
   end

   // catch write-back to the held channel while the multiply stage waits
   always_comb begin
      fwd_vld_in  = fwd_vld_ff;
      fwd_data_in = fwd_data_ff;
      if (s1_free) begin
         fwd_vld_in = 1'b0;
      end else if (wr_en && wr_idx == idx1) begin
         fwd_vld_in  = 1'b1;
         fwd_data_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_vld_ff <= 1'b0;
      end else begin
         fwd_vld_ff <= fwd_vld_in;
      end
      fwd_data_ff <= fwd_data_in;
   end

   assign eff = fwd_vld_ff ? fwd_data_ff : (rd_vld_ff ? rd_data_ff : '0);

   // ---------------- multiply stage ----------------
   always_comb begin
      v1_in   = v1_ff;
      ch1_in  = ch1_ff;
      x_s1_in = x_s1_ff;
      if (s1_free) begin
         v1_in   = accept && in_range;
         ch1_in  = req_bus.channel;
         x_s1_in = req_bus.sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
      ch1_ff  <= ch1_in;
      x_s1_ff <= x_s1_in;
   end

   always_comb begin
      v2_in    = v2_ff;
      ch2_in   = ch2_ff;
      x_s2_in  = x_s2_ff;
      xp_s2_in = xp_s2_ff;
      yp_s2_in = yp_s2_ff;
      p0_in    = p0_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      p3_in    = p3_ff;
      p4_in    = p4_ff;
      if (s2_free) begin
         v2_in = mv1;
      end
      if (s2_free && mv1) begin
         ch2_in   = ch1_ff;
         x_s2_in  = x_s1_ff;
         xp_s2_in = eff.x1;
         yp_s2_in = eff.y1;
         p0_in    = coef_ff[0] * x_s1_ff;
         p1_in    = coef_ff[1] * eff.x1;
         p2_in    = coef_ff[2] * eff.x2;
         p3_in    = coef_ff[3] * eff.y1;
         p4_in    = coef_ff[4] * eff.y2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
      ch2_ff   <= ch2_in;
      x_s2_ff  <= x_s2_in;
      xp_s2_ff <= xp_s2_in;
      yp_s2_ff <= yp_s2_in;
      p0_ff    <= p0_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      p3_ff    <= p3_in;
      p4_ff    <= p4_in;
   end

   // ---------------- sum, round, saturate ----------------
   always_comb begin
      acc = ACC_W'(p0_ff) + ACC_W'(p1_ff) + ACC_W'(p2_ff)
          - ACC_W'(p3_ff) - ACC_W'(p4_ff) + RND;
      rnd = R_W'(acc >>> mbq_pkg::FRAC_BITS);
      sat = 1'b0;
      if (rnd > MAX_R) begin
         y   = MAX_S;
         sat = 1'b1;
      end else if (rnd < MIN_R) begin
         y   = MIN_S;
         sat = 1'b1;
      end else begin
         y = rnd[SAMPLE_BITS-1:0];
      end
   end

   // ---------------- response register ----------------
   always_comb begin
      rsp_vld_in = out_free ? v2_ff : rsp_vld_ff;
      rsp_ch_in  = rsp_ch_ff;
      rsp_y_in   = rsp_y_ff;
      rsp_sat_in = rsp_sat_ff;
      if (wr_en) begin
         rsp_ch_in  = ch2_ff;
         rsp_y_in   = y;
         rsp_sat_in = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      rsp_ch_ff  <= rsp_ch_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.channel_out = rsp_ch_ff;
   assign rsp_bus.sample_out  = rsp_y_ff;
   assign rsp_bus.saturated   = rsp_sat_ff;

endmodule

>>> design/mbq_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbq_checker: port-level checks for the multichannel biquad low-pass filter
// Reset behavior, response hold under stall and saturation flag consistency.
// ---------------------------------------------------------------------------
module mbq_checker #(
   parameter int SAMPLE_BITS = mbq_pkg::SAMPLE_BITS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mbq_pkg::CHAN_W-1:0]    rsp_channel_out,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input logic                          rsp_saturated
);

   localparam logic signed [SAMPLE_BITS-1:0] MAX_S = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] MIN_S = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_reset_ready : assert property (@(posedge clock) $fell(reset) |-> req_ready)
      else $error("request not ready after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_channel_out)
         && $stable(rsp_sample_out) && $stable(rsp_saturated))
      else $error("stalled response transaction changed");

   a_sat_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> (rsp_sample_out == MAX_S) || (rsp_sample_out == MIN_S))
      else $error("saturated flag set on an unclipped sample");

endmodule

bind multichannel_biquad_lowpass mbq_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mbq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_channel_out (rsp_bus.channel_out),
   .rsp_sample_out  (rsp_bus.sample_out),
   .rsp_saturated   (rsp_bus.saturated)
);

>>> sim/tb_multichannel_biquad_lowpass.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_multichannel_biquad_lowpass: self-checking bench for the biquad filter
// Drives sample transactions on all channels with random gaps and response
// backpressure, programs the Q4.28 coefficients between phases, and checks
// every response against an in-bench direct form I filter with rounding and
// saturation.
// ---------------------------------------------------------------------------
module tb_multichannel_biquad_lowpass;

   localparam int     SAMPLE_W      = mbq_pkg::SAMPLE_BITS_DEF;
   localparam int     NUM_CHANNELS  = mbq_pkg::CHANNELS_DEF;
   localparam int     CYCLE_LIMIT   = 1_000_000;
   localparam int     SETTLE_CYCLES = 8;
   localparam int     PRINT_LIMIT   = 40;
   localparam int     RANDOM_PHASES = 8;
   localparam int     PHASE_ITEMS   = 200;
   localparam int     HOLD_CYCLES   = 300;
   localparam int     REG_UNUSED_FIRST = mbq_pkg::NUM_COEF;
   localparam int     REG_INDEX_LAST   = (1 << mbq_pkg::CSR_IDX_W) - 1;

   typedef logic [mbq_pkg::CHAN_W-1:0]    chan_type;
   typedef logic [mbq_pkg::CSR_IDX_W-1:0] csr_idx_type;
   typedef logic signed [SAMPLE_W-1:0]    sample_type;

   localparam sample_type        SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam sample_type        SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam mbq_pkg::coef_type Q_ONE      = 32'sh1000_0000;
   localparam mbq_pkg::coef_type Q_HALF     = 32'sh0800_0000;
   localparam mbq_pkg::coef_type COEF_MAX   = 32'sh7FFF_FFFF;
   localparam mbq_pkg::coef_type COEF_MIN   = 32'sh8000_0000;

   typedef enum int {
      SET_DEFAULT,
      SET_LOWPASS,
      SET_WIDE,
      SET_NARROW,
      SET_EXTREME
   } coef_mode_type;

   typedef struct packed {
      logic [mbq_pkg::CHAN_W-1:0] channel;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       saturated;
   } filt_out_type;

   logic clock;
   logic reset;

   mbq_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_bus ();
   mbq_rsp_if #(.SAMPLE_BITS(SAMPLE_W)) rsp_bus ();
   mbq_csr_if                           csr_bus ();

   multichannel_biquad_lowpass #(
      .CHANNELS   (NUM_CHANNELS),
      .SAMPLE_BITS(SAMPLE_W)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   mbq_pkg::coef_type          coef_q    [mbq_pkg::NUM_COEF];
   logic signed [SAMPLE_W-1:0] hist_in1  [NUM_CHANNELS];
   logic signed [SAMPLE_W-1:0] hist_in2  [NUM_CHANNELS];
   logic signed [SAMPLE_W-1:0] hist_out1 [NUM_CHANNELS];
   logic signed [SAMPLE_W-1:0] hist_out2 [NUM_CHANNELS];
   filt_out_type               pending_out [$];
   filt_out_type               got_out;
   filt_out_type               want_out;

   int                error_count    = 0;
   int                cycle_count    = 0;
   int                samples_sent   = 0;
   int                results_seen   = 0;
   int                saturated_seen = 0;
   int                settings_used  = 0;
   int                repeat_hits    = 0;
   int                rsp_hold_len   = 0;
   bit                send_gaps_on   = 1'b0;
   bit                rsp_stalls_on  = 1'b0;
   chan_type          last_channel   = '0;

   function automatic filt_out_type filter_sample(input chan_type ch,
                                                  input logic signed [SAMPLE_W-1:0] x);
      longint       acc;
      longint       y;
      filt_out_type res;
      acc = longint'(coef_q[mbq_pkg::REG_NUM_COEF0]) * longint'(x)
          + longint'(coef_q[mbq_pkg::REG_NUM_COEF1]) * longint'(hist_in1[ch])
          + longint'(coef_q[mbq_pkg::REG_NUM_COEF2]) * longint'(hist_in2[ch])
          - longint'(coef_q[mbq_pkg::REG_DEN_COEF1]) * longint'(hist_out1[ch])
          - longint'(coef_q[mbq_pkg::REG_DEN_COEF2]) * longint'(hist_out2[ch]);
      acc = acc + (longint'(1) <<< (mbq_pkg::FRAC_BITS - 1));
      y = acc >>> mbq_pkg::FRAC_BITS;
      res.channel   = ch;
      res.saturated = 1'b0;
      if (y > SAMPLE_MAX) begin
         y = SAMPLE_MAX;
         res.saturated = 1'b1;
      end else if (y < SAMPLE_MIN) begin
         y = SAMPLE_MIN;
         res.saturated = 1'b1;
      end
      res.sample = y[SAMPLE_W-1:0];
      hist_in2[ch]  = hist_in1[ch];
      hist_in1[ch]  = x;
      hist_out2[ch] = hist_out1[ch];
      hist_out1[ch] = res.sample;
      return res;
   endfunction

   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic sample_type random_sample();
      int pick;
      pick = $urandom_range(0, 19);
      case (pick)
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return 0;
         3:       return -1;
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic mbq_pkg::coef_type extreme_coef();
      int pick;
      pick = $urandom_range(0, 4);
      case (pick)
         0:       return COEF_MAX;
         1:       return COEF_MIN;
         2:       return Q_ONE;
         3:       return -Q_ONE;
         default: return 0;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (error_count < PRINT_LIMIT)
         $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   task automatic send_sample(input chan_type ch, input logic signed [SAMPLE_W-1:0] x);
      int gap;
      gap = send_gaps_on ? idle_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.channel   <= ch;
      req_bus.sample_in <= x;
      do @(posedge clock); while (!req_bus.ready);
      pending_out.push_back(filter_sample(ch, x));
      if (samples_sent > 0 && ch == last_channel) repeat_hits++;
      last_channel = ch;
      samples_sent++;
   endtask

   task automatic drain_outputs();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_coef(input csr_idx_type idx,
                             input logic [mbq_pkg::COEF_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx < mbq_pkg::NUM_COEF) coef_q[idx] = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic program_coefs(input mbq_pkg::coef_type n0, input mbq_pkg::coef_type n1,
                                input mbq_pkg::coef_type n2, input mbq_pkg::coef_type d1,
                                input mbq_pkg::coef_type d2);
      drain_outputs();
      write_coef(mbq_pkg::REG_NUM_COEF0, n0);
      write_coef(mbq_pkg::REG_NUM_COEF1, n1);
      write_coef(mbq_pkg::REG_NUM_COEF2, n2);
      write_coef(mbq_pkg::REG_DEN_COEF1, d1);
      write_coef(mbq_pkg::REG_DEN_COEF2, d2);
      settings_used++;
   endtask

   // stable poles, unity gain at DC
   task automatic program_lowpass();
      int     radius;
      int     span;
      longint d1;
      longint d2;
      longint n0;
      radius = $urandom_range(128, 243);
      d2     = longint'(radius * radius) <<< 12;
      span   = (1 << mbq_pkg::FRAC_BITS) + int'(d2) - (1 << 24);
      d1     = longint'($urandom_range(0, span));
      if ($urandom_range(0, 3) != 0) d1 = -d1;
      n0     = ((longint'(1) <<< mbq_pkg::FRAC_BITS) + d1 + d2) / 4;
      program_coefs(mbq_pkg::coef_type'(n0), mbq_pkg::coef_type'(2 * n0),
                    mbq_pkg::coef_type'(n0), mbq_pkg::coef_type'(d1),
                    mbq_pkg::coef_type'(d2));
   endtask

   task automatic program_mode(input coef_mode_type mode);
      mbq_pkg::coef_type c [mbq_pkg::NUM_COEF];
      case (mode)
         SET_DEFAULT: program_coefs(mbq_pkg::COEF_RESET[0], mbq_pkg::COEF_RESET[1],
                                    mbq_pkg::COEF_RESET[2], mbq_pkg::COEF_RESET[3],
                                    mbq_pkg::COEF_RESET[4]);
         SET_LOWPASS: program_lowpass();
         default: begin
            for (int i = 0; i < mbq_pkg::NUM_COEF; i++) begin
               if (mode == SET_WIDE)
                  c[i] = $urandom;
               else if (mode == SET_NARROW)
                  c[i] = int'($urandom_range(0, 1 << (mbq_pkg::FRAC_BITS + 1)))
                       - (1 << mbq_pkg::FRAC_BITS);
               else
                  c[i] = extreme_coef();
            end
            program_coefs(c[0], c[1], c[2], c[3], c[4]);
         end
      endcase
   endtask

   function automatic coef_mode_type phase_mode(input int phase);
      case (phase % 8)
         0:       return SET_DEFAULT;
         2:       return SET_WIDE;
         4:       return SET_NARROW;
         5:       return SET_EXTREME;
         7:       return SET_WIDE;
         default: return SET_LOWPASS;
      endcase
   endfunction

   task automatic test_reset_coefs();
      send_gaps_on  = 1'b1;
      rsp_stalls_on = 1'b1;
      send_sample(0, SAMPLE_MAX);
      send_sample(31, SAMPLE_MIN);
      send_sample(0, 0);
      send_sample(31, -1);
      send_sample(5, 1);
   endtask

   task automatic test_coef_extremes();
      program_coefs(COEF_MAX, 0, 0, 0, 0);
      send_sample(1, SAMPLE_MAX);
      send_sample(2, SAMPLE_MIN);
      program_coefs(COEF_MIN, 0, 0, 0, 0);
      for (int idx = REG_UNUSED_FIRST; idx <= REG_INDEX_LAST; idx++)
         write_coef(csr_idx_type'(idx), $urandom);
      send_sample(3, SAMPLE_MAX);
      send_sample(4, SAMPLE_MIN);
      program_coefs(Q_HALF, 0, 0, 0, 0);
      send_sample(6, 1);
      send_sample(6, -1);
      send_sample(6, 3);
      send_sample(6, -3);
      program_coefs(0, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
      send_sample(7, SAMPLE_MAX);
      send_sample(7, SAMPLE_MIN);
      send_sample(7, 12345);
      send_sample(7, -1);
      program_coefs(0, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
      send_sample(8, SAMPLE_MIN);
      send_sample(8, SAMPLE_MAX);
      send_sample(8, 0);
   endtask

   task automatic test_same_channel_burst();
      program_lowpass();
      send_gaps_on  = 1'b0;
      rsp_stalls_on = 1'b0;
      repeat (4) send_sample(9, random_sample());
      send_sample(10, random_sample());
      send_sample(9, random_sample());
   endtask

   task automatic test_output_backpressure();
      program_lowpass();
      send_gaps_on  = 1'b0;
      rsp_stalls_on = 1'b1;
      rsp_hold_len  = HOLD_CYCLES;
      repeat (80) send_sample(chan_type'($urandom_range(0, NUM_CHANNELS - 1)),
                              random_sample());
      drain_outputs();
   endtask

   task automatic test_random_phases();
      chan_type focus;
      chan_type ch;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         program_mode(phase_mode(phase));
         send_gaps_on  = (phase % 3 != 0);
         rsp_stalls_on = (phase % 4 != 0);
         focus = chan_type'($urandom_range(0, NUM_CHANNELS - 1));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (phase == 3 && i == PHASE_ITEMS / 2) drain_outputs();
            if ($urandom_range(0, 9) < 3)
               ch = chan_type'(focus + $urandom_range(0, 1));
            else
               ch = chan_type'($urandom_range(0, NUM_CHANNELS - 1));
            send_sample(ch, random_sample());
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_out.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : rsp_ready_gen
      int gap;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len > 0) begin
            gap = rsp_hold_len;
            rsp_hold_len = 0;
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else if (rsp_stalls_on) begin
            gap = idle_gap();
            if (gap > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_out.channel   = rsp_bus.channel_out;
         got_out.sample    = rsp_bus.sample_out;
         got_out.saturated = rsp_bus.saturated;
         if (pending_out.size() == 0) begin
            report_mismatch("response with nothing pending, sample_out",
                            $signed(got_out.sample), 0);
         end else begin
            want_out = pending_out.pop_front();
            if (got_out.channel !== want_out.channel)
               report_mismatch("channel_out", got_out.channel, want_out.channel);
            if (got_out.sample !== want_out.sample)
               report_mismatch($sformatf("sample_out ch %0d", want_out.channel),
                               $signed(got_out.sample), $signed(want_out.sample));
            if (got_out.saturated !== want_out.saturated)
               report_mismatch($sformatf("saturated ch %0d", want_out.channel),
                               got_out.saturated, want_out.saturated);
            results_seen++;
            if (want_out.saturated) saturated_seen++;
         end
      end
   end

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.channel   = '0;
      req_bus.sample_in = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      for (int i = 0; i < mbq_pkg::NUM_COEF; i++) coef_q[i] = mbq_pkg::COEF_RESET[i];
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         hist_in1[i]  = '0;
         hist_in2[i]  = '0;
         hist_out1[i] = '0;
         hist_out2[i] = '0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_coefs();
      test_coef_extremes();
      test_same_channel_burst();
      test_output_backpressure();
      test_random_phases();
      drain_outputs();

      $display("Summary: %0d samples over %0d channels, %0d coefficient settings",
               samples_sent, NUM_CHANNELS, settings_used);
      $display("Summary: %0d responses checked, %0d clipped, %0d same-channel repeats",
               results_seen, saturated_seen, repeat_hits);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
